FILE: rtl/core/bpq_pkg.sv
// Shared codes, constants and types for the bucket priority queue.
package bpq_pkg;

  // Operation codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Widest bucket index the search can report (up to 256 buckets)
  localparam int MAX_BUCKET_W = 8;
  // Buckets per first-level group of the highest-bucket search
  localparam int GROUP_W = 16;

  typedef struct packed {
    logic                    found;
    logic [MAX_BUCKET_W-1:0] idx;
  } srch_t;

endpackage

FILE: rtl/core/bpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bpq_search.sv
// Two-level highest non-empty bucket search: registered group stage, then group select.
module bpq_search #(
  parameter int NUM_BUCKETS = 64
) (
  input  logic                   clk_i,
  input  logic [NUM_BUCKETS-1:0] ne_i,
  output bpq_pkg::srch_t         srch_o
);

  localparam int GW   = $clog2(bpq_pkg::GROUP_W);
  localparam int NG   = (NUM_BUCKETS + bpq_pkg::GROUP_W - 1) / bpq_pkg::GROUP_W;
  localparam int PADW = NG * bpq_pkg::GROUP_W;
  localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;

  logic [PADW-1:0] ne_pad;
  logic [NG-1:0]   grp_any_d, grp_any_q;
  logic [GW-1:0]   grp_low_d [NG];
  logic [GW-1:0]   grp_low_q [NG];
  logic [GIW-1:0]  sel_g;
  logic            found;

  assign ne_pad = PADW'(ne_i);

  // Per group: any bit set, and the highest set position within it
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_d[g] = |ne_pad[g*bpq_pkg::GROUP_W +: bpq_pkg::GROUP_W];
      grp_low_d[g] = '0;
      for (int i = 0; i < bpq_pkg::GROUP_W; i++) begin
        if (ne_pad[g*bpq_pkg::GROUP_W + i]) begin
          grp_low_d[g] = GW'(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    grp_low_q <= grp_low_d;
  end

  always_comb begin
    sel_g = '0;
    found = 1'b0;
    for (int g = 0; g < NG; g++) begin
      if (grp_any_q[g]) begin
        sel_g = GIW'(g);
        found = 1'b1;
      end
    end
  end

  assign srch_o.found = found;
  assign srch_o.idx   = bpq_pkg::MAX_BUCKET_W'({sel_g, grp_low_q[sel_g]});

endmodule

FILE: rtl/core/bucket_priority_queue.sv
// Bucket priority queue: LIFO buckets in RAM, max-bucket pointer, pop from highest bucket.
// An add reads the fill-count RAM, then writes the word and the new count; a remove reads
// the fill count, writes it back decremented while reading the word RAM, and, when it empties
// its bucket, then waits on the two-level bucket search for the new pointer.
// One item in flight; a finished result may wait in the output register while the next runs.
// Reset (async, active low) clears all buckets, the pointer and both channels.
module bucket_priority_queue #(
  parameter int NUM_BUCKETS  = 64,
  parameter int BUCKET_DEPTH = 32,
  parameter int WORD_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [5:0]  bucket_i,
  input  logic [31:0] item_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] removed_word_o,
  output logic        removed_valid_o,
  output logic        queue_empty_o,
  output logic [1:0]  status_o
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int DW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FW = $clog2(BUCKET_DEPTH + 1);
  localparam int AW = BW + DW;
  localparam int STORE_DEPTH = NUM_BUCKETS * (2 ** DW);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_SRCH = 2'd3;

  logic [1:0]             state_q, state_d;
  logic                   op_q;
  logic [5:0]             bkt_q;
  logic [31:0]            word_q;
  logic [BW-1:0]          cur_bkt_q, cur_bkt_d;
  logic [BW-1:0]          top_q, top_d;
  logic [NUM_BUCKETS-1:0] ne_q, ne_d;
  logic                   pop_last_q, pop_last_d;
  logic [31:0]            popped_q;

  logic                   in_acc;
  logic                   in_range;
  logic [FW-1:0]          fill_cur;
  logic [FW-1:0]          fill_dec;

  logic                   fill_we, fill_re;
  logic [BW-1:0]          fill_waddr, fill_raddr;
  logic [FW-1:0]          fill_wdata, fill_rdata;
  logic                   st_we, st_re;
  logic [AW-1:0]          st_waddr, st_raddr;
  logic [WORD_WIDTH-1:0]  st_wdata, st_rdata;

  bpq_pkg::srch_t         srch;

  // Result skid register and output register
  logic                   res_load;
  logic                   res_valid_q;
  logic [31:0]            res_word_q, res_word_d;
  logic                   res_rvalid_q, res_rvalid_d;
  logic                   res_empty_q, res_empty_d;
  bpq_pkg::status_e       res_status_q, res_status_d;
  logic                   out_valid_q;
  logic [31:0]            out_word_q;
  logic                   out_rvalid_q;
  logic                   out_empty_q;
  bpq_pkg::status_e       out_status_q;
  logic                   out_free;
  logic                   res_move;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign res_move   = res_valid_q && out_free;
  assign in_stall_o = (state_q != S_IDLE) || (res_valid_q && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_range = 32'(bkt_q) < 32'(NUM_BUCKETS);
  // A bucket whose non-empty bit is clear holds no words, whatever its RAM entry says
  assign fill_cur = ne_q[cur_bkt_q] ? fill_rdata : '0;
  assign fill_dec = fill_cur - FW'(1);

  bpq_ram #(
    .WIDTH (FW),
    .DEPTH (NUM_BUCKETS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .re_i    (fill_re),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  bpq_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  bpq_search #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_search (
    .clk_i  (clk_i),
    .ne_i   (ne_q),
    .srch_o (srch)
  );

  always_comb begin
    state_d      = state_q;
    cur_bkt_d    = cur_bkt_q;
    top_d        = top_q;
    ne_d         = ne_q;
    pop_last_d   = pop_last_q;
    fill_re      = 1'b0;
    fill_raddr   = (operation_i == bpq_pkg::OP_ADD) ? BW'(bucket_i) : top_q;
    fill_we      = 1'b0;
    fill_waddr   = cur_bkt_q;
    fill_wdata   = fill_cur + FW'(1);
    st_we        = 1'b0;
    st_waddr     = {cur_bkt_q, DW'(fill_cur)};
    st_wdata     = WORD_WIDTH'(word_q);
    st_re        = 1'b0;
    st_raddr     = {cur_bkt_q, DW'(fill_dec)};
    res_load     = 1'b0;
    res_word_d   = '0;
    res_rvalid_d = 1'b0;
    res_empty_d  = ~|ne_q;
    res_status_d = bpq_pkg::ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          fill_re   = 1'b1;
          cur_bkt_d = fill_raddr;
          state_d   = S_FILL;
        end
      end
      S_FILL: begin
        res_load = 1'b1;
        state_d  = S_IDLE;
        if (op_q == bpq_pkg::OP_ADD) begin
          priority if (!in_range || fill_cur == FW'(BUCKET_DEPTH)) begin
            res_status_d = bpq_pkg::ST_FULL;
          end else begin
            st_we            = 1'b1;
            fill_we          = 1'b1;
            ne_d[cur_bkt_q]  = 1'b1;
            res_empty_d      = 1'b0;
            if (cur_bkt_q > top_q) begin
              top_d = cur_bkt_q;
            end
          end
        end else begin
          if (!ne_q[cur_bkt_q]) begin
            res_status_d = bpq_pkg::ST_EMPTY;
            res_empty_d  = 1'b1;
          end else begin
            res_load   = 1'b0;
            fill_we    = 1'b1;
            fill_wdata = fill_dec;
            st_re      = 1'b1;
            pop_last_d = (fill_dec == '0);
            if (fill_dec == '0) begin
              ne_d[cur_bkt_q] = 1'b0;
            end
            state_d = S_POP;
          end
        end
      end
      S_POP: begin
        if (pop_last_q) begin
          state_d = S_SRCH;
        end else begin
          res_load     = 1'b1;
          res_word_d   = 32'(st_rdata);
          res_rvalid_d = 1'b1;
          res_empty_d  = 1'b0;
          state_d      = S_IDLE;
        end
      end
      S_SRCH: begin
        // Buckets above the pointer are always empty, so the new pointer is the highest
        // non-empty bucket, or bucket 0 when none is left
        top_d        = srch.found ? BW'(srch.idx) : '0;
        res_load     = 1'b1;
        res_word_d   = popped_q;
        res_rvalid_d = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      ne_q        <= '0;
      pop_last_q  <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      top_q      <= top_d;
      ne_q       <= ne_d;
      pop_last_q <= pop_last_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_move) begin
        res_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= res_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_bkt_q <= cur_bkt_d;
    if (in_acc) begin
      op_q   <= operation_i;
      bkt_q  <= bucket_i;
      word_q <= item_word_i;
    end
    if (state_q == S_POP) begin
      popped_q <= 32'(st_rdata);
    end
    if (res_load) begin
      res_word_q   <= res_word_d;
      res_rvalid_q <= res_rvalid_d;
      res_empty_q  <= res_empty_d;
      res_status_q <= res_status_d;
    end
    if (res_move) begin
      out_word_q   <= res_word_q;
      out_rvalid_q <= res_rvalid_q;
      out_empty_q  <= res_empty_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_word_o  = out_word_q;
  assign removed_valid_o = out_rvalid_q;
  assign queue_empty_o   = out_empty_q;
  assign status_o        = out_status_q;

  // The skid register is always free when an item finishes
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !res_valid_q)
    else $error("result overwrites a waiting result");

  // Between items the pointer names a non-empty bucket unless the queue is empty
  a_top_ne: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (ne_q == '0 || ne_q[top_q]))
    else $error("max-bucket pointer not on a non-empty bucket");

  // An accepted item always starts with the fill-count read
  a_acc_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_FILL))
    else $error("accepted item did not enter fill stage");

  // Only a successful remove carries a word
  a_rvalid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && removed_valid_o) |-> (status_o == bpq_pkg::ST_OK))
    else $error("popped word with error status");

endmodule

FILE: bench/tb.sv
// Self-checking bench for the bucket priority queue: directed cases, overflow, random mix.
`timescale 1ns / 1ps

module tb;

  localparam int NBUCKETS    = 64;
  localparam int BKT_DEPTH   = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 20;

  typedef struct {
    logic [31:0]      word;
    logic             valid;
    logic             empty;
    bpq_pkg::status_e status;
  } pq_result_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        operation = bpq_pkg::OP_ADD;
  logic [5:0]  bucket    = '0;
  logic [31:0] item_word = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] removed_word;
  logic        removed_valid;
  logic        queue_empty;
  logic [1:0]  status;

  // shadow copy of the queue contents
  logic [31:0] pq_words [NBUCKETS][BKT_DEPTH];
  int          pq_fill  [NBUCKETS];
  int          pq_top;

  pq_result_t  pending_results [$];
  pq_result_t  want;
  int          errors      = 0;
  int          cycle_count = 0;
  int          stall_left  = 0;
  int          hold_left   = 0;
  bit          idle_on     = 1'b0;

  bucket_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .bucket_i       (bucket),
    .item_word_i    (item_word),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .removed_word_o (removed_word),
    .removed_valid_o(removed_valid),
    .queue_empty_o  (queue_empty),
    .status_o       (status)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bucket_priority_queue: mismatch");
      $finish;
    end
  end

  task automatic flag_mismatch(string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Applies one item to the shadow queue and returns the result it should give.
  function automatic pq_result_t predict_pq(logic op, logic [5:0] bkt, logic [31:0] w);
    pq_result_t r;
    int         b;
    r = '{32'd0, 1'b0, 1'b0, bpq_pkg::ST_OK};
    b = bkt;
    if (op == bpq_pkg::OP_ADD) begin
      // 6-bit bucket field cannot leave the 64-bucket range, so only fullness drops an add
      if (pq_fill[b] >= BKT_DEPTH) begin
        r.status = bpq_pkg::ST_FULL;
      end else begin
        pq_words[b][pq_fill[b]] = w;
        pq_fill[b]++;
        if (b > pq_top) pq_top = b;
      end
    end else if (pq_fill[pq_top] == 0) begin
      r.status = bpq_pkg::ST_EMPTY;
    end else begin
      pq_fill[pq_top]--;
      r.word  = pq_words[pq_top][pq_fill[pq_top]];
      r.valid = 1'b1;
      while (pq_fill[pq_top] == 0 && pq_top != 0) pq_top--;
    end
    r.empty = (pq_fill[pq_top] == 0);
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result arrived with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        if (removed_word !== want.word)
          flag_mismatch($sformatf("removed_word %h, want %h", removed_word, want.word));
        if (removed_valid !== want.valid)
          flag_mismatch($sformatf("removed_valid %b, want %b", removed_valid, want.valid));
        if (queue_empty !== want.empty)
          flag_mismatch($sformatf("queue_empty %b, want %b", queue_empty, want.empty));
        if (status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one item and returns at the edge where it is taken; valid stays high.
  task automatic send_item(logic op, logic [5:0] bkt, logic [31:0] w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    bucket    <= bkt;
    item_word <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_results.push_back(predict_pq(op, bkt, w));
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    idle_on = 1'b1;
    send_item(bpq_pkg::OP_REMOVE, 6'd63, 32'hFFFF_FFFF);  // remove on empty queue
    send_item(bpq_pkg::OP_ADD,    6'd0,  32'h0000_0000);
    send_item(bpq_pkg::OP_ADD,    6'd63, 32'hFFFF_FFFF);
    send_item(bpq_pkg::OP_ADD,    6'd63, 32'h5555_5555);
    send_item(bpq_pkg::OP_ADD,    6'd31, 32'hAAAA_AAAA);
    send_item(bpq_pkg::OP_ADD,    6'd1,  32'h0000_0001);  // below pointer, no raise
    send_item(bpq_pkg::OP_REMOVE, 6'd0,  32'h0);          // newest of bucket 63
    send_item(bpq_pkg::OP_REMOVE, 6'd0,  32'h0);          // pointer walks down to 31
    send_item(bpq_pkg::OP_REMOVE, 6'd0,  32'h0);          // walks down to 1
    send_item(bpq_pkg::OP_ADD,    6'd0,  32'h8000_0000);
    send_item(bpq_pkg::OP_REMOVE, 6'd0,  32'h0);
    send_item(bpq_pkg::OP_REMOVE, 6'd0,  32'h0);
    send_item(bpq_pkg::OP_REMOVE, 6'd0,  32'h0);          // queue drains
    send_item(bpq_pkg::OP_REMOVE, 6'd21, 32'h1234_5678);
    send_item(bpq_pkg::OP_ADD,    6'd42, 32'h1234_5678);
    send_item(bpq_pkg::OP_ADD,    6'd21, 32'hDEAD_BEEF);
    send_item(bpq_pkg::OP_REMOVE, 6'd0,  32'h0);
    send_item(bpq_pkg::OP_REMOVE, 6'd0,  32'h0);
  endtask

  // Fills one bucket past its depth, then drains it and removes once more.
  task automatic test_bucket_overflow(logic [5:0] bkt);
    repeat (BKT_DEPTH + 2) send_item(bpq_pkg::OP_ADD, bkt, pick_word());
    repeat (BKT_DEPTH + 1) send_item(bpq_pkg::OP_REMOVE, 6'($urandom_range(0, 63)), $urandom());
  endtask

  // Phases of random length, each with its own add ratio and bucket window.
  task automatic test_random_mix(int n_items, bit allow_idle);
    int   done;
    int   phase_len;
    int   add_pct;
    int   lo;
    int   span;
    int   b;
    logic op;
    done = 0;
    while (done < n_items) begin
      phase_len = $urandom_range(20, 120);
      add_pct   = $urandom_range(25, 90);
      idle_on   = allow_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) begin
        lo   = $urandom_range(0, 63);
        span = $urandom_range(0, 3);
      end else begin
        lo   = 0;
        span = 63;
      end
      repeat (phase_len) begin
        op = ($urandom_range(0, 99) < add_pct) ? bpq_pkg::OP_ADD : bpq_pkg::OP_REMOVE;
        b  = lo + $urandom_range(0, span);
        if (b > 63) b = 63;
        send_item(op, 6'(b), pick_word());
        done++;
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the input backs up.
  task automatic test_backpressure();
    idle_on   = 1'b0;
    hold_left = 400;
    repeat (40) send_item(($urandom_range(0, 2) == 0) ? bpq_pkg::OP_REMOVE : bpq_pkg::OP_ADD,
                          6'($urandom_range(0, 63)), pick_word());
    while (hold_left > 0) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < NBUCKETS; i++) pq_fill[i] = 0;
    pq_top = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_bucket_overflow(6'd63);
    test_bucket_overflow(6'd0);
    test_random_mix(1150, 1'b1);
    test_backpressure();
    test_random_mix(250, 1'b0);

    in_valid <= 1'b0;
    idle_on = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (errors == 0) begin
      $display("bucket_priority_queue: match");
    end else begin
      $display("bucket_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bpq_pkg.sv
rtl/core/bpq_ram.sv
rtl/core/bpq_search.sv
rtl/core/bucket_priority_queue.sv
bench/tb.sv
